// ===== src/rcsel_pkg.sv =====
// Shared types and constants of the radio-control source selector.
package rcsel_pkg;

	localparam int TS_W   = 32;
	localparam int PW_W   = 16;
	localparam int CNT_W  = 5;
	localparam int SRC_W  = 2;
	localparam int CH_W   = 4;
	localparam int FSRC_W = 3;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;

	localparam logic [1:0] OP_FRAME    = 2'd0;
	localparam logic [1:0] OP_VALUE    = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;
	localparam logic [1:0] OP_OVERRIDE = 2'd3;

	localparam logic [CFG_AW-1:0] REG_FORCED_SOURCE = 3'd0;
	localparam logic [CFG_AW-1:0] REG_FAILSAFE_EN   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_MODE_FS_EN    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_FRAME_GAP     = 3'd3;
	localparam logic [CFG_AW-1:0] REG_LOSS_LIMIT    = 3'd4;
	localparam logic [CFG_AW-1:0] REG_DEAD_TIME     = 3'd5;

	localparam logic [15:0] FRAME_GAP_RST  = 16'd50;
	localparam logic [15:0] LOSS_LIMIT_RST = 16'd500;
	localparam logic [15:0] DEAD_TIME_RST  = 16'd500;

	localparam logic [PW_W-1:0] THR_DEFAULT    = 16'd900;
	localparam logic [PW_W-1:0] CH_DEFAULT     = 16'd1000;
	localparam logic [PW_W-1:0] MODE_LOW_LIMIT = 16'd1000;
	localparam logic [PW_W-1:0] THR_CUT_LIMIT  = 16'd1300;

	localparam logic [CH_W-1:0] THR_CH  = 4'd2;
	localparam logic [CH_W-1:0] MODE_CH = 4'd4;

	typedef struct packed {
		logic [FSRC_W-1:0] forced_source;
		logic              failsafe_en;
		logic              mode_fs_en;
		logic [15:0]       frame_gap;
		logic [15:0]       loss_limit;
		logic [15:0]       dead_time;
	} cfg_t;

	typedef struct packed {
		logic [1:0]             opcode;
		logic [SRC_W-1:0]       source;
		logic [CH_W-1:0]        channel;
		logic signed [PW_W-1:0] pulse_value;
		logic [TS_W-1:0]        frame_stamp;
		logic [TS_W-1:0]        change_stamp;
		logic [CNT_W-1:0]       channel_count;
		logic [TS_W-1:0]        now_ms;
	} in_item_t;

	typedef struct packed {
		logic [PW_W-1:0]   channel_value;
		logic [CNT_W-1:0]  valid_channels;
		logic [FSRC_W-1:0] source_used;
		logic              override_set;
	} out_item_t;

	typedef struct packed {
		logic [TS_W-1:0] diff;
		logic            lt;
	} cmp_res_t;

endpackage

// ===== src/rcsel_if.sv =====
// Handshake interfaces of the selector: input items, results and register writes.
interface rcsel_in_if import rcsel_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rcsel_out_if import rcsel_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rcsel_cfg_if import rcsel_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] addr;
	logic [CFG_DW-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== src/rcsel_cfg_regs.sv =====
// Configuration register file of the selector.
module rcsel_cfg_regs import rcsel_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rcsel_cfg_if.sink cfg,
	output cfg_t regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.forced_source <= '0;
			regs_q.failsafe_en   <= 1'b0;
			regs_q.mode_fs_en    <= 1'b0;
			regs_q.frame_gap     <= FRAME_GAP_RST;
			regs_q.loss_limit    <= LOSS_LIMIT_RST;
			regs_q.dead_time     <= DEAD_TIME_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_FORCED_SOURCE: regs_q.forced_source <= cfg.data[FSRC_W-1:0];
				REG_FAILSAFE_EN:   regs_q.failsafe_en   <= cfg.data[0];
				REG_MODE_FS_EN:    regs_q.mode_fs_en    <= cfg.data[0];
				REG_FRAME_GAP:     regs_q.frame_gap     <= cfg.data[15:0];
				REG_LOSS_LIMIT:    regs_q.loss_limit    <= cfg.data[15:0];
				REG_DEAD_TIME:     regs_q.dead_time     <= cfg.data[15:0];
				default: begin
					// unknown register: drop the write
				end
			endcase
		end
	end

endmodule

// ===== src/rcsel_sub_cmp.sv =====
// Shared subtract-and-compare unit: diff = a - b (mod 2^32), lt = diff < c.
module rcsel_sub_cmp import rcsel_pkg::*; (
	input  logic [TS_W-1:0] a,
	input  logic [TS_W-1:0] b,
	input  logic [TS_W-1:0] c,
	output cmp_res_t        res
);

	logic [TS_W-1:0] diff;

	assign diff     = a - b;
	assign res.diff = diff;
	assign res.lt   = diff < c;

endmodule

// ===== src/rcsel_value_mem.sv =====
// Per-source channel value memory with valid bits; unwritten entries read as zero.
module rcsel_value_mem import rcsel_pkg::*; #(
	parameter int NUM_SOURCES = 4,
	parameter int CHAN_COUNT  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [((NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1)-1:0] wr_src,
	input  logic [$clog2(CHAN_COUNT)-1:0] wr_ch,
	input  logic [PW_W-1:0] wr_data,
	input  logic [((NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1)-1:0] rd_src,
	input  logic [$clog2(CHAN_COUNT)-1:0] rd_ch,
	output logic [PW_W-1:0] rd_data
);

	logic [PW_W-1:0] mem [NUM_SOURCES][CHAN_COUNT];
	logic [NUM_SOURCES-1:0][CHAN_COUNT-1:0] vld_q;
	logic [PW_W-1:0] rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_src][wr_ch] <= wr_data;
		end
		rd_q <= mem[rd_src][rd_ch];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_src][wr_ch] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_src][rd_ch];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== src/rc_source_select_failsafe_unit.sv =====
// Top level of the radio-control source selector with throttle failsafe.
//
//  port     | role   | carries
//  ---------+--------+-------------------------------------------------
//  cfg      | sink   | register writes: addr, data (always ready)
//  in_ch    | sink   | items: frame, value, read, override
//  out_ch   | source | results: value, valid channels, source, override
//
// Frame and value items are stored on acceptance and keep the input ready.
// Override items and reads of an unknown channel go straight to ST_DONE; the
// result enters the output register from there once that register is free.
// A read runs ST_CHECK, ST_SCAN if needed, ST_USE, ST_LOST, ST_DEAD, ST_DONE;
// the scan runs three passes per source through the one subtract-compare unit.
// Reset clears all state at once; there is no clearing pass.
// A finished result waits in its own state while the output register is full.
module rc_source_select_failsafe_unit import rcsel_pkg::*; #(
	parameter int NUM_SOURCES = 4,
	parameter int CHAN_COUNT  = 16
) (
	input  logic clk,
	input  logic arst_n,
	rcsel_cfg_if.sink    cfg,
	rcsel_in_if.sink     in_ch,
	rcsel_out_if.source  out_ch
);

	localparam int SIW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int CIW = $clog2(CHAN_COUNT);
	localparam int SNW = $clog2(NUM_SOURCES + 1);
	localparam logic [SNW-1:0] NSRC     = SNW'(NUM_SOURCES);
	localparam logic [SIW-1:0] LAST_IDX = SIW'(NUM_SOURCES - 1);

	localparam logic [1:0] PH_NEWER  = 2'd0;
	localparam logic [1:0] PH_CLOSER = 2'd1;
	localparam logic [1:0] PH_ALIVE  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_SCAN, ST_USE, ST_LOST, ST_DEAD, ST_DONE
	} state_t;

	cfg_t     cfg_q;
	in_item_t pl;
	cmp_res_t cmp;

	state_t           state_q;
	logic [1:0]       phase_q;
	logic [SIW-1:0]   scan_q;
	logic [CH_W-1:0]  ch_q;
	logic [TS_W-1:0]  now_q;
	logic [TS_W-1:0]  best_q;
	logic [TS_W-1:0]  dt_q;
	logic             newer_q;
	logic             closer_q;
	logic [SNW-1:0]   got_q;
	logic [SNW-1:0]   used_q;
	logic [TS_W-1:0]  pulse_q;
	logic [TS_W-1:0]  last_q;
	logic [PW_W-1:0]  data_q;
	logic             lost_trip_q;
	logic [TS_W-1:0]  last_read_q;
	logic [SNW-1:0]   last_src_q;
	logic [PW_W-1:0]  last_mode_q;
	logic [CNT_W-1:0] cur_valid_q;
	out_item_t        res_q;
	out_item_t        out_item_q;
	logic             out_valid_q;

	logic [TS_W-1:0]  frame_q  [NUM_SOURCES];
	logic [TS_W-1:0]  change_q [NUM_SOURCES];
	logic [CNT_W-1:0] count_q  [NUM_SOURCES];
	logic [PW_W-1:0]  ovr_q    [CHAN_COUNT];

	logic             in_acc;
	logic             src_ok;
	logic             in_ch_ok;
	logic             forced_ok;
	logic [SNW-1:0]   used_c;
	logic [SIW-1:0]   used_idx;
	logic [SIW-1:0]   meta_idx;
	logic [TS_W-1:0]  meta_f;
	logic [TS_W-1:0]  meta_c;
	logic [CNT_W-1:0] meta_n;
	logic [CIW-1:0]   ch_idx;
	logic [PW_W-1:0]  ovr_rd;
	logic [PW_W-1:0]  thr_value;
	logic [PW_W-1:0]  final_value;
	logic [PW_W-1:0]  mem_rd;
	logic             mem_we;
	logic [TS_W-1:0]  op_a;
	logic [TS_W-1:0]  op_b;
	logic [TS_W-1:0]  op_c;

	rcsel_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_q)
	);

	rcsel_sub_cmp u_cmp (
		.a   (op_a),
		.b   (op_b),
		.c   (op_c),
		.res (cmp)
	);

	rcsel_value_mem #(
		.NUM_SOURCES (NUM_SOURCES),
		.CHAN_COUNT  (CHAN_COUNT)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_src  (SIW'(pl.source)),
		.wr_ch   (CIW'(pl.channel)),
		.wr_data ($unsigned(pl.pulse_value)),
		.rd_src  (used_idx),
		.rd_ch   (ch_idx),
		.rd_data (mem_rd)
	);

	assign pl             = in_ch.payload;
	assign in_ch.ready    = (state_q == ST_IDLE);
	assign in_acc         = in_ch.valid && in_ch.ready;
	assign src_ok         = 32'(pl.source) < NUM_SOURCES;
	assign in_ch_ok       = 32'(pl.channel) < CHAN_COUNT;
	assign mem_we         = in_acc && (pl.opcode == OP_VALUE) && src_ok && in_ch_ok;
	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_item_q;

	assign forced_ok = (cfg_q.forced_source != '0) && (32'(cfg_q.forced_source) <= NUM_SOURCES);
	assign used_c    = (got_q != '0) ? got_q :
		((last_src_q != '0 && last_src_q <= NSRC) ? last_src_q : '0);
	assign used_idx  = SIW'(used_c - SNW'(1));
	assign meta_idx  = (state_q == ST_SCAN) ? scan_q : used_idx;
	assign meta_f    = frame_q[meta_idx];
	assign meta_c    = change_q[meta_idx];
	assign meta_n    = count_q[meta_idx];
	assign ch_idx    = CIW'(ch_q);
	assign ovr_rd    = ovr_q[ch_idx];

	// operand select for the shared unit
	always_comb begin
		op_a = now_q;
		op_b = '0;
		op_c = '0;
		unique case (state_q)
			ST_CHECK: begin
				op_b = last_read_q;
				op_c = 32'(cfg_q.frame_gap) + 32'd1;
			end
			ST_SCAN: begin
				unique case (phase_q)
					PH_NEWER: begin
						op_a = last_read_q;
						op_c = meta_f;
					end
					PH_CLOSER: begin
						op_b = meta_f;
						op_c = best_q;
					end
					default: begin
						op_b = meta_c;
						op_c = 32'(cfg_q.dead_time);
					end
				endcase
			end
			ST_LOST: begin
				op_b = pulse_q;
				op_c = 32'(cfg_q.loss_limit) + 32'd1;
			end
			ST_DEAD: begin
				op_b = last_q;
				op_c = 32'(cfg_q.dead_time) + 32'd1;
			end
			default: begin
				op_a = now_q;
			end
		endcase
	end

	// throttle failsafe and override on the fetched value
	always_comb begin
		thr_value = data_q;
		if (lost_trip_q || !cmp.lt) begin
			thr_value = THR_DEFAULT;
		end
		if (cfg_q.mode_fs_en && last_mode_q < MODE_LOW_LIMIT && thr_value > THR_CUT_LIMIT) begin
			thr_value = THR_DEFAULT;
		end
		if (ovr_rd != '0) begin
			final_value = ovr_rd;
		end else if (ch_q == THR_CH && cfg_q.failsafe_en) begin
			final_value = thr_value;
		end else begin
			final_value = data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				frame_q[i]  <= '0;
				change_q[i] <= '0;
				count_q[i]  <= '0;
			end
		end else if (in_acc && pl.opcode == OP_FRAME && src_ok) begin
			frame_q[SIW'(pl.source)]  <= pl.frame_stamp;
			change_q[SIW'(pl.source)] <= pl.change_stamp;
			count_q[SIW'(pl.source)]  <= pl.channel_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHAN_COUNT; i++) begin
				ovr_q[i] <= '0;
			end
		end else if (in_acc && pl.opcode == OP_OVERRIDE && !pl.pulse_value[PW_W-1] &&
				in_ch_ok) begin
			ovr_q[CIW'(pl.channel)] <= $unsigned(pl.pulse_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_NEWER;
			scan_q      <= '0;
			ch_q        <= '0;
			now_q       <= '0;
			best_q      <= '0;
			dt_q        <= '0;
			newer_q     <= 1'b0;
			closer_q    <= 1'b0;
			got_q       <= '0;
			used_q      <= '0;
			pulse_q     <= '0;
			last_q      <= '0;
			data_q      <= '0;
			lost_trip_q <= 1'b0;
			last_read_q <= '0;
			last_src_q  <= '0;
			last_mode_q <= '0;
			cur_valid_q <= '0;
			res_q       <= '0;
			out_item_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished word or drop the one taken by the receiver
			if (state_q == ST_DONE && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						ch_q  <= pl.channel;
						now_q <= pl.now_ms;
						if (pl.opcode == OP_READ) begin
							if (in_ch_ok) begin
								state_q <= ST_CHECK;
							end else begin
								res_q.channel_value  <= '0;
								res_q.valid_channels <= cur_valid_q;
								res_q.source_used    <= FSRC_W'(last_src_q);
								res_q.override_set   <= 1'b0;
								state_q              <= ST_DONE;
							end
						end else if (pl.opcode == OP_OVERRIDE) begin
							res_q.channel_value  <= '0;
							res_q.valid_channels <= '0;
							res_q.source_used    <= '0;
							res_q.override_set   <= !pl.pulse_value[PW_W-1] && in_ch_ok &&
								(pl.pulse_value != '0);
							state_q              <= ST_DONE;
						end
					end
				end
				ST_CHECK: begin
					best_q  <= '1;
					scan_q  <= '0;
					phase_q <= PH_NEWER;
					if (forced_ok) begin
						got_q   <= SNW'(cfg_q.forced_source);
						state_q <= ST_USE;
					end else begin
						got_q <= '0;
						if (!cmp.lt) begin
							// frame time has passed since the last read
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_USE;
						end
					end
				end
				ST_SCAN: begin
					unique case (phase_q)
						PH_NEWER: begin
							newer_q <= cmp.lt;
							phase_q <= PH_CLOSER;
						end
						PH_CLOSER: begin
							dt_q     <= cmp.diff;
							closer_q <= cmp.lt;
							phase_q  <= PH_ALIVE;
						end
						default: begin
							if (newer_q && closer_q && (cmp.lt || !cfg_q.failsafe_en)) begin
								best_q <= dt_q;
								got_q  <= SNW'(scan_q) + SNW'(1);
							end
							phase_q <= PH_NEWER;
							if (scan_q == LAST_IDX) begin
								state_q <= ST_USE;
							end else begin
								scan_q <= scan_q + SIW'(1);
							end
						end
					endcase
				end
				ST_USE: begin
					used_q <= used_c;
					if (got_q != '0) begin
						last_src_q <= got_q;
					end
					if (used_c != '0) begin
						pulse_q     <= meta_f;
						last_q      <= meta_c;
						cur_valid_q <= meta_n;
						last_read_q <= meta_f;
					end else begin
						pulse_q <= '0;
						last_q  <= '0;
					end
					state_q <= ST_LOST;
				end
				ST_LOST: begin
					lost_trip_q <= !cmp.lt;
					if (used_q != '0) begin
						data_q <= mem_rd;
					end else begin
						data_q <= (ch_q == THR_CH) ? THR_DEFAULT : CH_DEFAULT;
					end
					state_q <= ST_DEAD;
				end
				ST_DEAD: begin
					if (ovr_rd == '0 && ch_q == MODE_CH) begin
						last_mode_q <= data_q;
					end
					res_q.channel_value  <= final_value;
					res_q.valid_channels <= cur_valid_q;
					res_q.source_used    <= FSRC_W'(used_q);
					res_q.override_set   <= 1'b0;
					state_q              <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_item_q <= res_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/rcsel_checker.sv =====
// Port-level checks of the selector, bound to the top level.
module rcsel_port_checks import rcsel_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [1:0]           in_opcode,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [PW_W-1:0]      out_value,
	input logic [CNT_W-1:0]     out_count,
	input logic [FSRC_W-1:0]    out_used,
	input logic                 out_ovr
);

	a_busy_after_result_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode == OP_READ || in_opcode == OP_OVERRIDE)
		|=> !in_ready)
		else $error("block took a word while working on a read or override");

	a_silent_store_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode == OP_FRAME || in_opcode == OP_VALUE)
		|=> in_ready && !$rose(out_valid))
		else $error("store word produced a result or stalled the input");

	a_override_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ovr |-> out_value == '0 && out_used == '0 && out_count == '0)
		else $error("override result carries channel data");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_used))
		else $error("stalled result word changed");

endmodule

bind rc_source_select_failsafe_unit rcsel_port_checks u_rcsel_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_opcode (in_ch.payload.opcode),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.payload.channel_value),
	.out_count (out_ch.payload.valid_channels),
	.out_used  (out_ch.payload.source_used),
	.out_ovr   (out_ch.payload.override_set)
);
